// File: hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reported by label
`define XNS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("port protocol check failed");

// next-cycle implication, reported by label
`define XNS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("port protocol check failed");

`endif

// File: hdl/xns_pkg.sv
// types, constants and character class functions for the name scanner
// no dependencies
`timescale 1ns / 1ps

package xns_pkg;

   localparam int CP_BITS        = 21;
   localparam int ADV_BITS       = 12;
   localparam int QUOTE_BITS     = 8;
   localparam int OP_BITS        = 2;
   localparam int COUNT_BITS_DEF = 12;

   localparam logic [CP_BITS-1:0] CP_END    = 21'h00000;
   localparam logic [CP_BITS-1:0] CP_EQ     = 21'h0003D;
   localparam logic [CP_BITS-1:0] CP_DQUOTE = 21'h00022;
   localparam logic [CP_BITS-1:0] CP_SQUOTE = 21'h00027;

   typedef enum logic [OP_BITS-1:0] {
      OP_ELEM   = 2'd0,
      OP_ATTR   = 2'd1,
      OP_VALUE  = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_ELEM     = 4'd1,
      PH_ATTR     = 4'd2,
      PH_VALUE    = 4'd3,
      PH_WALK     = 4'd4,
      PH_WS_END   = 4'd5,
      PH_AFTER_EQ = 4'd6,
      PH_QUOTED   = 4'd7,
      PH_UNQUOTED = 4'd8
   } phase_type;

   typedef struct packed {
      logic is_end;
      logic is_ws;
      logic is_start;
      logic is_namec;
      logic is_eq;
      logic is_quote;
   } class_type;

   typedef struct packed {
      logic                done;
      logic                ok;
      logic                end_seen;
      logic [ADV_BITS-1:0] advance;
   } rslt_type;

   function automatic logic in_rng(input logic [CP_BITS-1:0] c,
                                   input logic [CP_BITS-1:0] lo,
                                   input logic [CP_BITS-1:0] hi);
      return (c >= lo) && (c <= hi);
   endfunction

   function automatic logic is_ws(input logic [CP_BITS-1:0] c);
      return c == 21'h09 || c == 21'h0A || c == 21'h0C || c == 21'h0D ||
             c == 21'h20 || c == 21'hA0 || c == 21'h1680 ||
             in_rng(c, 21'h2000, 21'h200A) || c == 21'h2028 || c == 21'h2029 ||
             c == 21'h202F || c == 21'h205F || c == 21'h3000;
   endfunction

   function automatic logic is_start(input logic [CP_BITS-1:0] c);
      return in_rng(c, 21'h41, 21'h5A) || in_rng(c, 21'h61, 21'h7A) ||
             c == 21'h3A || c == 21'h5F ||
             in_rng(c, 21'hC0, 21'hD6) || in_rng(c, 21'hD8, 21'hF6) ||
             in_rng(c, 21'hF8, 21'h2FF) || in_rng(c, 21'h370, 21'h37D) ||
             in_rng(c, 21'h37F, 21'h1FFF) || in_rng(c, 21'h200C, 21'h200D) ||
             in_rng(c, 21'h2070, 21'h218F) || in_rng(c, 21'h2C00, 21'h2FEF) ||
             in_rng(c, 21'h3001, 21'hD7FF) || in_rng(c, 21'hF900, 21'hFDCF) ||
             in_rng(c, 21'hFDF0, 21'hFFFD) || in_rng(c, 21'h10000, 21'hEFFFF);
   endfunction

   function automatic logic is_namec(input logic [CP_BITS-1:0] c);
      return is_start(c) || c == 21'h2D || c == 21'h2E ||
             in_rng(c, 21'h30, 21'h39) || c == 21'hB7 ||
             in_rng(c, 21'h300, 21'h36F) || in_rng(c, 21'h203F, 21'h2040);
   endfunction

endpackage

// File: hdl/xns_classify.sv
// character class decode of one code point
// depends on xns_pkg
`timescale 1ns / 1ps

module xns_classify (
   input  logic [xns_pkg::CP_BITS-1:0] code_point,
   output xns_pkg::class_type          cls
);
   import xns_pkg::*;

   always_comb begin
      cls.is_end   = (code_point == CP_END);
      cls.is_ws    = is_ws(code_point);
      cls.is_start = is_start(code_point);
      cls.is_namec = is_namec(code_point);
      cls.is_eq    = (code_point == CP_EQ);
      cls.is_quote = (code_point == CP_DQUOTE) || (code_point == CP_SQUOTE);
   end

endmodule

// File: hdl/xns_step.sv
// scan state machine: phase, count, quote and space registers, one beat per fire
// depends on xns_pkg
`timescale 1ns / 1ps

module xns_step #(
   parameter int COUNT_BITS = xns_pkg::COUNT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fire,
   input  logic [xns_pkg::CP_BITS-1:0]    code_point,
   input  logic                           start_req,
   input  logic [xns_pkg::OP_BITS-1:0]    op,
   input  logic [xns_pkg::QUOTE_BITS-1:0] quote_char,
   input  xns_pkg::class_type             cls,
   output xns_pkg::rslt_type              rslt
);
   import xns_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [QUOTE_BITS-1:0]   quote_ff, quote_in;
   logic                    saw_ff, saw_in;

   phase_type               eff_phase;
   logic [COUNT_BITS-1:0]   eff_count;
   logic [QUOTE_BITS-1:0]   eff_quote;
   logic                    eff_saw;
   logic                    first;
   logic                    name_ok;
   logic                    quote_hit;
   logic                    inc;
   logic [COUNT_BITS-1:0]   count_bumped;
   logic [ADV_BITS-1:0]     adv_sat;
   logic                    done, ok, end_seen;

   // effective state after a start beat
   always_comb begin
      eff_count = start_req ? '0 : count_ff;
      eff_saw   = start_req ? 1'b0 : saw_ff;
      eff_quote = quote_ff;
      eff_phase = phase_ff;
      first     = 1'b0;
      if (start_req) begin
         eff_quote = '0;
         unique case (op_type'(op))
            OP_ELEM: begin
               eff_phase = PH_ELEM;
               first     = 1'b1;
            end
            OP_ATTR: begin
               eff_phase = PH_ATTR;
               first     = 1'b1;
            end
            OP_VALUE: begin
               eff_phase = PH_VALUE;
               eff_quote = quote_char;
            end
            OP_UNUSED: eff_phase = PH_IDLE;
         endcase
      end
   end

   assign name_ok   = first ? cls.is_start : cls.is_namec;
   assign quote_hit = (code_point == {{(CP_BITS-QUOTE_BITS){1'b0}}, eff_quote});

   // next state
   always_comb begin
      phase_in = eff_phase;
      quote_in = eff_quote;
      saw_in   = eff_saw;
      inc      = 1'b0;
      unique case (eff_phase)
         PH_IDLE: phase_in = PH_IDLE;
         PH_ELEM: begin
            if (cls.is_end) phase_in = PH_IDLE;
            else if (name_ok) inc = 1'b1;
            else phase_in = PH_IDLE;
         end
         PH_ATTR: begin
            if (cls.is_end) phase_in = PH_IDLE;
            else if (name_ok) inc = 1'b1;
            else if (first) begin
               phase_in = PH_IDLE;
               inc      = !cls.is_ws;
            end else if (cls.is_ws || cls.is_eq) phase_in = PH_IDLE;
            else begin
               inc      = 1'b1;
               phase_in = PH_WALK;
            end
         end
         PH_VALUE: begin
            if (cls.is_end) phase_in = PH_IDLE;
            else begin
               inc = 1'b1;
               if (quote_hit) phase_in = PH_IDLE;
            end
         end
         PH_WALK: begin
            if (cls.is_end) phase_in = PH_IDLE;
            else begin
               inc = 1'b1;
               if (cls.is_ws) phase_in = PH_WS_END;
               else if (cls.is_eq) phase_in = PH_AFTER_EQ;
            end
         end
         PH_WS_END: begin
            if (cls.is_end) phase_in = PH_IDLE;
            else if (cls.is_ws) inc = 1'b1;
            else phase_in = PH_IDLE;
         end
         PH_AFTER_EQ: begin
            if (cls.is_end) phase_in = PH_IDLE;
            else if (cls.is_ws) begin
               inc    = 1'b1;
               saw_in = 1'b1;
            end else if (cls.is_quote) begin
               inc      = 1'b1;
               quote_in = code_point[QUOTE_BITS-1:0];
               phase_in = PH_QUOTED;
            end else if (eff_saw) phase_in = PH_IDLE;
            else begin
               inc      = 1'b1;
               phase_in = PH_UNQUOTED;
            end
         end
         PH_QUOTED: begin
            if (cls.is_end) phase_in = PH_IDLE;
            else begin
               inc = 1'b1;
               if (quote_hit) phase_in = PH_WS_END;
            end
         end
         PH_UNQUOTED: begin
            if (cls.is_end || cls.is_ws) phase_in = PH_IDLE;
            else inc = 1'b1;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // result flags
   always_comb begin
      done     = 1'b0;
      ok       = 1'b0;
      end_seen = 1'b0;
      unique case (eff_phase)
         PH_IDLE: done = 1'b0;
         PH_ELEM: begin
            if (cls.is_end) begin
               done     = 1'b1;
               ok       = 1'b1;
               end_seen = 1'b1;
            end else if (!name_ok) begin
               done = 1'b1;
               ok   = cls.is_ws;
            end
         end
         PH_ATTR: begin
            if (cls.is_end) begin
               done     = 1'b1;
               ok       = 1'b1;
               end_seen = 1'b1;
            end else if (!name_ok) begin
               if (first) begin
                  done = 1'b1;
                  ok   = cls.is_ws;
               end else if (cls.is_ws || cls.is_eq) begin
                  done = 1'b1;
                  ok   = 1'b1;
               end
            end
         end
         PH_VALUE: begin
            if (cls.is_end) begin
               done     = 1'b1;
               end_seen = 1'b1;
            end else if (quote_hit) begin
               done = 1'b1;
               ok   = 1'b1;
            end
         end
         PH_WALK, PH_QUOTED: begin
            done     = cls.is_end;
            end_seen = cls.is_end;
         end
         PH_WS_END: begin
            done     = cls.is_end || !cls.is_ws;
            end_seen = cls.is_end;
         end
         PH_AFTER_EQ: begin
            done     = cls.is_end || (!cls.is_ws && !cls.is_quote && eff_saw);
            end_seen = cls.is_end;
         end
         PH_UNQUOTED: begin
            done     = cls.is_end || cls.is_ws;
            end_seen = cls.is_end;
         end
         default: done = 1'b0;
      endcase
   end

   assign count_bumped = (inc && (eff_count != '1)) ? eff_count + COUNT_BITS'(1) : eff_count;
   assign count_in     = count_bumped;

   generate
      if (COUNT_BITS > ADV_BITS) begin : g_adv_clip
         assign adv_sat = (|count_bumped[COUNT_BITS-1:ADV_BITS]) ?
                          '1 : count_bumped[ADV_BITS-1:0];
      end else begin : g_adv_ext
         assign adv_sat = ADV_BITS'(count_bumped);
      end
   endgenerate

   always_comb begin
      rslt.done     = done;
      rslt.ok       = ok;
      rslt.end_seen = end_seen;
      rslt.advance  = adv_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         quote_ff <= '0;
         saw_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         quote_ff <= quote_in;
         saw_ff   <= saw_in;
      end
   end

endmodule

// File: hdl/xml_name_and_attribute_scanner.sv
// a scan's last beat passes the input register and then the result register
// throughput: one code point per cycle unless the result register is stalled,
// set by the combinational scan step between the input and result registers
// reset: synchronous, active high; clears both registers' valid bits and the
// scan state to idle with a zero count
`timescale 1ns / 1ps

module xml_name_and_attribute_scanner #(
   parameter int COUNT_BITS = xns_pkg::COUNT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [xns_pkg::CP_BITS-1:0]    req_code_point,
   input  logic                           req_start_req,
   input  logic [xns_pkg::OP_BITS-1:0]    req_op,
   input  logic [xns_pkg::QUOTE_BITS-1:0] req_quote_char,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [xns_pkg::ADV_BITS-1:0]   rsp_advance,
   output logic                           rsp_ok,
   output logic                           rsp_end_seen
);
   import xns_pkg::*;

   logic                  in_valid_ff;
   logic [CP_BITS-1:0]    cp_ff;
   logic                  start_ff;
   logic [OP_BITS-1:0]    op_ff;
   logic [QUOTE_BITS-1:0] quote_ff;

   logic                  out_valid_ff, out_valid_in;
   logic [ADV_BITS-1:0]   adv_ff;
   logic                  ok_ff;
   logic                  end_ff;

   logic                  out_free;
   logic                  fire;
   class_type             cls;
   rslt_type              rslt;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cp_ff    <= req_code_point;
         start_ff <= req_start_req;
         op_ff    <= req_op;
         quote_ff <= req_quote_char;
      end
   end

   xns_classify u_classify (
      .code_point (cp_ff),
      .cls        (cls)
   );

   xns_step #(
      .COUNT_BITS (COUNT_BITS)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .code_point (cp_ff),
      .start_req  (start_ff),
      .op         (op_ff),
      .quote_char (quote_ff),
      .cls        (cls),
      .rslt       (rslt)
   );

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (fire) begin
         out_valid_in = rslt.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && rslt.done) begin
         adv_ff <= rslt.advance;
         ok_ff  <= rslt.ok;
         end_ff <= rslt.end_seen;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_advance  = adv_ff;
   assign rsp_ok       = ok_ff;
   assign rsp_end_seen = end_ff;

endmodule

// File: hdl/xns_checker.sv
// port-level checks for the name scanner, bound to the top level
// depends on assert_macros.svh and xml_name_and_attribute_scanner
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xns_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [xns_pkg::ADV_BITS-1:0] rsp_advance,
   input logic                         rsp_ok,
   input logic                         rsp_end_seen
);

   // a stalled result beat stays
   `XNS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a stalled result beat keeps its payload
   `XNS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_advance) && $stable(rsp_ok) && $stable(rsp_end_seen))

   // with the result register empty the input side takes a beat
   `XNS_ASSERT_IMPL(a_ready_free, clock, reset, !rsp_valid, req_ready)

   // a fresh result beat traces back to a request beat taken by the input register
   `XNS_ASSERT_IMPL(a_rsp_cause, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2))

endmodule

bind xml_name_and_attribute_scanner xns_checker u_xns_checker (.*);
